>>> rtl/core/huc_pkg.sv
package huc_pkg;

  localparam int unsigned TokenLen     = 26;
  localparam int unsigned PrefixLen    = 7;
  localparam int unsigned StatusStart  = 9;
  localparam int unsigned MinHeader    = 12;
  localparam int unsigned WantedStatus = 101;
  localparam int unsigned StatusW      = 24;
  localparam int unsigned LengthW      = 16;
  localparam int unsigned VerdictW     = 2;
  localparam int unsigned OutDataW     = 48;
  localparam int unsigned TokIdxW      = 5;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_OK          = 2'd0,
    VERDICT_BAD_STATUS  = 2'd1,
    VERDICT_BAD_UPGRADE = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_SPACE  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } digit_phase_e;

  typedef enum logic [1:0] {
    TP_NONE   = 2'd0,
    TP_CR     = 2'd1,
    TP_CRLF   = 2'd2,
    TP_CRLFCR = 2'd3
  } term_progress_e;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'h20;
    return r;
  endfunction

  // Expected status line prefix "HTTP/1.".
  function automatic logic [7:0] prefix_char(logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = "H";
      3'd1:    r = "T";
      3'd2:    r = "T";
      3'd3:    r = "P";
      3'd4:    r = "/";
      3'd5:    r = "1";
      3'd6:    r = ".";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Upgrade token, lower case, one character per position.
  function automatic logic [7:0] token_char(logic [TokIdxW-1:0] idx);
    logic [7:0] r;
    unique case (idx)
      5'd0:    r = "t";
      5'd1:    r = "a";
      5'd2:    r = "i";
      5'd3:    r = "l";
      5'd4:    r = "s";
      5'd5:    r = "c";
      5'd6:    r = "a";
      5'd7:    r = "l";
      5'd8:    r = "e";
      5'd9:    r = "-";
      5'd10:   r = "c";
      5'd11:   r = "o";
      5'd12:   r = "n";
      5'd13:   r = "t";
      5'd14:   r = "r";
      5'd15:   r = "o";
      5'd16:   r = "l";
      5'd17:   r = "-";
      5'd18:   r = "p";
      5'd19:   r = "r";
      5'd20:   r = "o";
      5'd21:   r = "t";
      5'd22:   r = "o";
      5'd23:   r = "c";
      5'd24:   r = "o";
      5'd25:   r = "l";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/http_upgrade_response_check_core.sv
// The result word is registered and appears on m_axis in the cycle after the byte that
// ends the header (the second LF of CR LF CR LF) is accepted.
// Throughput: one byte per cycle while s_axis_tready is high; every stage, including the
// token match cells, updates once per header byte. The output register frees s_axis_tready while a result is taken.
// Reset: rst_ni clears all state; the core is idle and ignores bytes until one has start set.
module http_upgrade_response_check_core #(
  parameter int unsigned HEADER_COUNT_LIMIT = 65535,
  parameter int unsigned MAX_STATUS_DIGITS  = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tuser,  // [0] start_req
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] verdict, [17:2] header_length, [41:18] status_number, [47:42] zero
  output logic [huc_pkg::OutDataW-1:0] m_axis_tdata
);
  import huc_pkg::*;

  localparam int unsigned CntW = $clog2(HEADER_COUNT_LIMIT + 1);
  localparam int unsigned DcW  = $clog2(MAX_STATUS_DIGITS + 1);

  logic                 active_q, active_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  term_progress_e       tp_q, tp_d;
  logic                 prefix_q, prefix_d;
  digit_phase_e         ph_q, ph_d;
  logic [DcW-1:0]       dcnt_q, dcnt_d;
  logic [StatusW-1:0]   acc_q, acc_d;
  logic                 tok_q, tok_d;
  logic                 m_valid_q, m_valid_d;
  logic [OutDataW-1:0]  m_data_q, m_data_d;

  logic                 s_fire;
  logic                 start;
  logic                 proc;
  logic [7:0]           b;
  logic                 hit;
  logic                 done;
  logic [CntW-1:0]      pos;
  logic [CntW+15:0]     cnt_ext;
  logic                 is_digit;
  verdict_e             verdict;
  logic [StatusW-1:0]   status;

  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign b             = s_axis_tdata;
  assign start         = s_axis_tuser;
  assign proc          = s_fire & (start | active_q);
  assign is_digit      = (b >= ChZero) && (b <= ChNine);

  huc_token_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc),
    .clr_i  (start),
    .byte_i (b),
    .hit_o  (hit)
  );

  always_comb begin
    active_d  = active_q;
    cnt_d     = start ? '0 : cnt_q;
    tp_d      = start ? TP_NONE : tp_q;
    prefix_d  = start ? 1'b1 : prefix_q;
    ph_d      = start ? PH_WAIT : ph_q;
    dcnt_d    = start ? '0 : dcnt_q;
    acc_d     = start ? '0 : acc_q;
    tok_d     = start ? 1'b0 : tok_q;
    pos       = cnt_d;
    done      = 1'b0;
    m_valid_d = m_valid_q & ~m_axis_tready;
    m_data_d  = m_data_q;
    verdict   = VERDICT_OK;
    status    = '0;
    cnt_ext   = '0;

    if (proc) begin
      active_d = 1'b1;
      if (pos < CntW'(HEADER_COUNT_LIMIT)) cnt_d = pos + CntW'(1);

      if (pos < CntW'(PrefixLen) && b != prefix_char(pos[2:0])) prefix_d = 1'b0;

      if (pos >= CntW'(StatusStart) && ph_d != PH_DONE) begin
        if ((ph_d == PH_WAIT || ph_d == PH_SPACE) && b == ChSpace) begin
          ph_d = PH_SPACE;
        end else if (is_digit && dcnt_d < DcW'(MAX_STATUS_DIGITS)) begin
          ph_d   = PH_DIGITS;
          acc_d  = (acc_d << 3) + (acc_d << 1) + StatusW'(b[3:0]);
          dcnt_d = dcnt_d + DcW'(1);
        end else begin
          ph_d = PH_DONE;
        end
      end

      if (hit) tok_d = 1'b1;

      priority if (b == ChCr) begin
        tp_d = (tp_d == TP_CRLF) ? TP_CRLFCR : TP_CR;
      end else if (b == ChLf) begin
        done = (tp_d == TP_CRLFCR);
        tp_d = (tp_d == TP_CR) ? TP_CRLF : TP_NONE;
      end else begin
        tp_d = TP_NONE;
      end

      if (done) begin
        if (cnt_d < CntW'(MinHeader) || !prefix_d || dcnt_d == '0) begin
          verdict = VERDICT_BAD_STATUS;
        end else begin
          status = acc_d;
          if (acc_d != StatusW'(WantedStatus)) verdict = VERDICT_BAD_STATUS;
          else if (!tok_d)                     verdict = VERDICT_BAD_UPGRADE;
          else                                 verdict = VERDICT_OK;
        end
        cnt_ext   = {16'b0, cnt_d};
        m_valid_d = 1'b1;
        m_data_d  = {(OutDataW - StatusW - LengthW - VerdictW)'(0), status,
                     cnt_ext[LengthW-1:0], verdict};
        active_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cnt_q     <= '0;
      tp_q      <= TP_NONE;
      prefix_q  <= 1'b0;
      ph_q      <= PH_WAIT;
      dcnt_q    <= '0;
      acc_q     <= '0;
      tok_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      if (proc) begin
        active_q <= active_d;
        cnt_q    <= cnt_d;
        tp_q     <= tp_d;
        prefix_q <= prefix_d;
        ph_q     <= ph_d;
        dcnt_q   <= dcnt_d;
        acc_q    <= acc_d;
        tok_q    <= tok_d;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> rtl/core/huc_token_cell.sv
module huc_token_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       prev_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] char_i,
  output logic       match_o
);

  logic match_q, match_d;

  // The cell is set when the newest byte continues a match held by its left neighbor.
  assign match_d = prev_i & (byte_i == char_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (en_i) begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

>>> rtl/core/huc_token_chain.sv
module huc_token_chain (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       clr_i,
  input  logic [7:0] byte_i,
  output logic       hit_o
);
  import huc_pkg::*;

  localparam int unsigned NumCells = TokenLen - 1;

  logic [7:0]          low;
  logic [NumCells-1:0] match;
  logic [NumCells-1:0] prev;

  assign low = fold_case(byte_i);

  // Cell k holds whether the last k+1 bytes equal the first k+1 token characters.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign prev[k] = 1'b1;
    end else begin : g_body
      assign prev[k] = match[k-1] & ~clr_i;
    end

    huc_token_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .prev_i  (prev[k]),
      .byte_i  (low),
      .char_i  (token_char(TokIdxW'(k))),
      .match_o (match[k])
    );
  end

  assign hit_o = match[NumCells-1] & ~clr_i & (low == token_char(TokIdxW'(TokenLen - 1)));

endmodule

>>> rtl/core/huc_checker.sv
module huc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [huc_pkg::OutDataW-1:0] m_axis_tdata
);
  import huc_pkg::*;

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // With the output register empty, the input side must be open.
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("undefined verdict code");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == VERDICT_OK |->
      m_axis_tdata[41:18] == 24'(WantedStatus))
    else $error("ok verdict with wrong status");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:42] == 6'd0))
    else $error("pad bits not zero");

endmodule

bind http_upgrade_response_check_core huc_checker u_huc_checker (.*);
